FILE: rtl/core/tcg_pkg.sv
// Shared types and constants for the terminal cell character generator.
// Holds the 5x7 font table, box-drawing code points and cell geometry.
// No dependencies.
package tcg_pkg;

	localparam int FONT_GLYPHS   = 95;
	localparam int CELL_WIDTH    = 6;
	localparam int CELL_HEIGHT   = 8;
	localparam int GLYPH_COLS    = 5;
	localparam int GLYPH_ROWS    = 7;
	localparam int UNDERLINE_ROW = 6;
	localparam int ROW_W         = $clog2(CELL_HEIGHT);
	localparam int IDX_W         = $clog2(FONT_GLYPHS);

	localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(CELL_HEIGHT - 1);

	// code points
	localparam logic [20:0] CP_FIRST_PRINT = 21'h00020;
	localparam logic [20:0] CP_LAST_PRINT  = 21'h0007e;
	localparam logic [20:0] CP_LIGHT_H     = 21'h02500;
	localparam logic [20:0] CP_HEAVY_H     = 21'h02501;
	localparam logic [20:0] CP_LIGHT_V     = 21'h02502;
	localparam logic [20:0] CP_HEAVY_V     = 21'h02503;
	localparam logic [20:0] CP_DOWN_RIGHT  = 21'h0250c;
	localparam logic [20:0] CP_DOWN_LEFT   = 21'h02510;
	localparam logic [20:0] CP_UP_RIGHT    = 21'h02514;
	localparam logic [20:0] CP_UP_LEFT     = 21'h02518;
	localparam logic [20:0] CP_VERT_RIGHT  = 21'h0251c;
	localparam logic [20:0] CP_VERT_LEFT   = 21'h02524;
	localparam logic [20:0] CP_DOWN_HORIZ  = 21'h0252c;
	localparam logic [20:0] CP_UP_HORIZ    = 21'h02534;
	localparam logic [20:0] CP_CROSS       = 21'h0253c;

	// font indexes of the box-drawing substitutes
	localparam logic [IDX_W-1:0] IDX_DASH = IDX_W'(8'h2d - 8'h20);
	localparam logic [IDX_W-1:0] IDX_BAR  = IDX_W'(8'h7c - 8'h20);
	localparam logic [IDX_W-1:0] IDX_PLUS = IDX_W'(8'h2b - 8'h20);

	// five columns, bit n of a column is glyph row n
	typedef logic [0:GLYPH_COLS-1][GLYPH_ROWS-1:0] glyph_t;
	typedef logic [CELL_WIDTH-1:0] row_pix_t;
	typedef logic [CELL_HEIGHT-1:0][CELL_WIDTH-1:0] cell_rows_t;

	localparam glyph_t FRAMED_BOX = {7'h7f, 7'h41, 7'h5d, 7'h41, 7'h7f};

	function automatic glyph_t font_cols(input logic [IDX_W-1:0] idx);
		glyph_t g;
		case (idx)
			7'd0:  g = {7'h00, 7'h00, 7'h00, 7'h00, 7'h00};
			7'd1:  g = {7'h00, 7'h00, 7'h5f, 7'h00, 7'h00};
			7'd2:  g = {7'h00, 7'h07, 7'h00, 7'h07, 7'h00};
			7'd3:  g = {7'h14, 7'h7f, 7'h14, 7'h7f, 7'h14};
			7'd4:  g = {7'h24, 7'h2a, 7'h7f, 7'h2a, 7'h12};
			7'd5:  g = {7'h23, 7'h13, 7'h08, 7'h64, 7'h62};
			7'd6:  g = {7'h36, 7'h49, 7'h55, 7'h22, 7'h50};
			7'd7:  g = {7'h00, 7'h05, 7'h03, 7'h00, 7'h00};
			7'd8:  g = {7'h00, 7'h1c, 7'h22, 7'h41, 7'h00};
			7'd9:  g = {7'h00, 7'h41, 7'h22, 7'h1c, 7'h00};
			7'd10: g = {7'h14, 7'h08, 7'h3e, 7'h08, 7'h14};
			7'd11: g = {7'h08, 7'h08, 7'h3e, 7'h08, 7'h08};
			7'd12: g = {7'h00, 7'h50, 7'h30, 7'h00, 7'h00};
			7'd13: g = {7'h08, 7'h08, 7'h08, 7'h08, 7'h08};
			7'd14: g = {7'h00, 7'h60, 7'h60, 7'h00, 7'h00};
			7'd15: g = {7'h20, 7'h10, 7'h08, 7'h04, 7'h02};
			7'd16: g = {7'h3e, 7'h51, 7'h49, 7'h45, 7'h3e};
			7'd17: g = {7'h00, 7'h42, 7'h7f, 7'h40, 7'h00};
			7'd18: g = {7'h42, 7'h61, 7'h51, 7'h49, 7'h46};
			7'd19: g = {7'h21, 7'h41, 7'h45, 7'h4b, 7'h31};
			7'd20: g = {7'h18, 7'h14, 7'h12, 7'h7f, 7'h10};
			7'd21: g = {7'h27, 7'h45, 7'h45, 7'h45, 7'h39};
			7'd22: g = {7'h3c, 7'h4a, 7'h49, 7'h49, 7'h30};
			7'd23: g = {7'h01, 7'h71, 7'h09, 7'h05, 7'h03};
			7'd24: g = {7'h36, 7'h49, 7'h49, 7'h49, 7'h36};
			7'd25: g = {7'h06, 7'h49, 7'h49, 7'h29, 7'h1e};
			7'd26: g = {7'h00, 7'h36, 7'h36, 7'h00, 7'h00};
			7'd27: g = {7'h00, 7'h56, 7'h36, 7'h00, 7'h00};
			7'd28: g = {7'h08, 7'h14, 7'h22, 7'h41, 7'h00};
			7'd29: g = {7'h14, 7'h14, 7'h14, 7'h14, 7'h14};
			7'd30: g = {7'h00, 7'h41, 7'h22, 7'h14, 7'h08};
			7'd31: g = {7'h02, 7'h01, 7'h51, 7'h09, 7'h06};
			7'd32: g = {7'h32, 7'h49, 7'h79, 7'h41, 7'h3e};
			7'd33: g = {7'h7e, 7'h11, 7'h11, 7'h11, 7'h7e};
			7'd34: g = {7'h7f, 7'h49, 7'h49, 7'h49, 7'h36};
			7'd35: g = {7'h3e, 7'h41, 7'h41, 7'h41, 7'h22};
			7'd36: g = {7'h7f, 7'h41, 7'h41, 7'h22, 7'h1c};
			7'd37: g = {7'h7f, 7'h49, 7'h49, 7'h49, 7'h41};
			7'd38: g = {7'h7f, 7'h09, 7'h09, 7'h09, 7'h01};
			7'd39: g = {7'h3e, 7'h41, 7'h49, 7'h49, 7'h7a};
			7'd40: g = {7'h7f, 7'h08, 7'h08, 7'h08, 7'h7f};
			7'd41: g = {7'h00, 7'h41, 7'h7f, 7'h41, 7'h00};
			7'd42: g = {7'h20, 7'h40, 7'h41, 7'h3f, 7'h01};
			7'd43: g = {7'h7f, 7'h08, 7'h14, 7'h22, 7'h41};
			7'd44: g = {7'h7f, 7'h40, 7'h40, 7'h40, 7'h40};
			7'd45: g = {7'h7f, 7'h02, 7'h0c, 7'h02, 7'h7f};
			7'd46: g = {7'h7f, 7'h04, 7'h08, 7'h10, 7'h7f};
			7'd47: g = {7'h3e, 7'h41, 7'h41, 7'h41, 7'h3e};
			7'd48: g = {7'h7f, 7'h09, 7'h09, 7'h09, 7'h06};
			7'd49: g = {7'h3e, 7'h41, 7'h51, 7'h21, 7'h5e};
			7'd50: g = {7'h7f, 7'h09, 7'h19, 7'h29, 7'h46};
			7'd51: g = {7'h46, 7'h49, 7'h49, 7'h49, 7'h31};
			7'd52: g = {7'h01, 7'h01, 7'h7f, 7'h01, 7'h01};
			7'd53: g = {7'h3f, 7'h40, 7'h40, 7'h40, 7'h3f};
			7'd54: g = {7'h1f, 7'h20, 7'h40, 7'h20, 7'h1f};
			7'd55: g = {7'h3f, 7'h40, 7'h38, 7'h40, 7'h3f};
			7'd56: g = {7'h63, 7'h14, 7'h08, 7'h14, 7'h63};
			7'd57: g = {7'h07, 7'h08, 7'h70, 7'h08, 7'h07};
			7'd58: g = {7'h61, 7'h51, 7'h49, 7'h45, 7'h43};
			7'd59: g = {7'h00, 7'h7f, 7'h41, 7'h41, 7'h00};
			7'd60: g = {7'h02, 7'h04, 7'h08, 7'h10, 7'h20};
			7'd61: g = {7'h00, 7'h41, 7'h41, 7'h7f, 7'h00};
			7'd62: g = {7'h04, 7'h02, 7'h01, 7'h02, 7'h04};
			7'd63: g = {7'h40, 7'h40, 7'h40, 7'h40, 7'h40};
			7'd64: g = {7'h00, 7'h01, 7'h02, 7'h04, 7'h00};
			7'd65: g = {7'h20, 7'h54, 7'h54, 7'h54, 7'h78};
			7'd66: g = {7'h7f, 7'h48, 7'h44, 7'h44, 7'h38};
			7'd67: g = {7'h38, 7'h44, 7'h44, 7'h44, 7'h20};
			7'd68: g = {7'h38, 7'h44, 7'h44, 7'h48, 7'h7f};
			7'd69: g = {7'h38, 7'h54, 7'h54, 7'h54, 7'h18};
			7'd70: g = {7'h08, 7'h7e, 7'h09, 7'h01, 7'h02};
			7'd71: g = {7'h0c, 7'h52, 7'h52, 7'h52, 7'h3e};
			7'd72: g = {7'h7f, 7'h08, 7'h04, 7'h04, 7'h78};
			7'd73: g = {7'h00, 7'h44, 7'h7d, 7'h40, 7'h00};
			7'd74: g = {7'h20, 7'h40, 7'h44, 7'h3d, 7'h00};
			7'd75: g = {7'h7f, 7'h10, 7'h28, 7'h44, 7'h00};
			7'd76: g = {7'h00, 7'h41, 7'h7f, 7'h40, 7'h00};
			7'd77: g = {7'h7c, 7'h04, 7'h18, 7'h04, 7'h78};
			7'd78: g = {7'h7c, 7'h08, 7'h04, 7'h04, 7'h78};
			7'd79: g = {7'h38, 7'h44, 7'h44, 7'h44, 7'h38};
			7'd80: g = {7'h7c, 7'h14, 7'h14, 7'h14, 7'h08};
			7'd81: g = {7'h08, 7'h14, 7'h14, 7'h18, 7'h7c};
			7'd82: g = {7'h7c, 7'h08, 7'h04, 7'h04, 7'h08};
			7'd83: g = {7'h48, 7'h54, 7'h54, 7'h54, 7'h20};
			7'd84: g = {7'h04, 7'h3f, 7'h44, 7'h40, 7'h20};
			7'd85: g = {7'h3c, 7'h40, 7'h40, 7'h20, 7'h7c};
			7'd86: g = {7'h1c, 7'h20, 7'h40, 7'h20, 7'h1c};
			7'd87: g = {7'h3c, 7'h40, 7'h30, 7'h40, 7'h3c};
			7'd88: g = {7'h44, 7'h28, 7'h10, 7'h28, 7'h44};
			7'd89: g = {7'h0c, 7'h50, 7'h50, 7'h50, 7'h3c};
			7'd90: g = {7'h44, 7'h64, 7'h54, 7'h4c, 7'h44};
			7'd91: g = {7'h00, 7'h08, 7'h36, 7'h41, 7'h00};
			7'd92: g = {7'h00, 7'h00, 7'h7f, 7'h00, 7'h00};
			7'd93: g = {7'h00, 7'h41, 7'h36, 7'h08, 7'h00};
			7'd94: g = {7'h08, 7'h04, 7'h08, 7'h10, 7'h08};
			default: g = FRAMED_BOX;
		endcase
		return g;
	endfunction

endpackage

FILE: rtl/core/terminal_cell_char_generator.sv
// Terminal cell character generator: one cell word in, eight row words out.
// Depends on tcg_pkg (font table, code points, cell types).
//
//   channel  direction  handshake               payload
//   cell     in         cell_valid / cell_stall  code_point, inverse_on, underline_on,
//                                               bold_on, cell_x, cell_y
//   row      out        row_valid / row_stall    row_pixels, row_index, pixel_x,
//                                               pixel_y, last_row
//
// Three stages (code map, font lookup, row build) feed a row register that
// sends one row per cycle while row_stall is low and holds a cell until its
// last row is taken; the stages can take new cells meanwhile. A taken cell word
// passes stages 1 to 3 and then the row register before its first row is valid.
// arst_n clears all valid bits and the row counter; payload is not reset.
// row_stall freezes the row register; the stages behind it fill and then
// raise cell_stall. A new cell loads as the last row of the previous one leaves.
module terminal_cell_char_generator
	import tcg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cell_valid,
	output logic        cell_stall,
	input  logic [20:0] code_point,
	input  logic        inverse_on,
	input  logic        underline_on,
	input  logic        bold_on,
	input  logic [9:0]  cell_x,
	input  logic [9:0]  cell_y,
	output logic        row_valid,
	input  logic        row_stall,
	output logic [5:0]  row_pixels,
	output logic [2:0]  row_index,
	output logic [9:0]  pixel_x,
	output logic [10:0] pixel_y,
	output logic        last_row
);

	// stage 1: mapped glyph index
	logic             v_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             font_s1;
	logic             inv_s1, ul_s1, bold_s1;
	logic [9:0]       x_s1, y_s1;

	// stage 2: glyph columns
	logic             v_s2;
	glyph_t           cols_s2;
	logic             inv_s2, ul_s2, bold_s2;
	logic [9:0]       x_s2, y_s2;

	// stage 3: finished rows
	logic             v_s3;
	cell_rows_t       rows_s3;
	logic [9:0]       x_s3, y_s3;

	// row register
	logic             busy_q;
	logic [ROW_W-1:0] row_q;
	cell_rows_t       rows_q;
	logic [9:0]       x_q, y_q;

	logic             ready_s1, ready_s2, ready_s3;
	logic             take, take_last, load_row;
	logic [IDX_W-1:0] idx_d;
	logic             font_d;
	cell_rows_t       rows_d;

	assign take      = busy_q && !row_stall;
	assign take_last = take && (row_q == LAST_ROW);
	assign load_row  = v_s3 && (!busy_q || take_last);
	assign ready_s3  = !v_s3 || load_row;
	assign ready_s2  = !v_s2 || ready_s3;
	assign ready_s1  = !v_s1 || ready_s2;
	assign cell_stall = !ready_s1;

	// box-drawing substitution and printable range check
	always_comb begin
		idx_d  = IDX_W'(code_point[6:0] - 7'h20);
		font_d = 1'b0;
		case (code_point) inside
			CP_LIGHT_H, CP_HEAVY_H: begin
				idx_d  = IDX_DASH;
				font_d = 1'b1;
			end
			CP_LIGHT_V, CP_HEAVY_V: begin
				idx_d  = IDX_BAR;
				font_d = 1'b1;
			end
			CP_DOWN_RIGHT, CP_DOWN_LEFT, CP_UP_RIGHT, CP_UP_LEFT, CP_VERT_RIGHT,
			CP_VERT_LEFT, CP_DOWN_HORIZ, CP_UP_HORIZ, CP_CROSS: begin
				idx_d  = IDX_PLUS;
				font_d = 1'b1;
			end
			[CP_FIRST_PRINT:CP_LAST_PRINT]: begin
				font_d = 1'b1;
			end
			default: begin
				font_d = 1'b0;
			end
		endcase
	end

	// transpose columns to rows, then underline, bold and inverse
	always_comb begin
		logic [GLYPH_COLS-1:0] lit;
		rows_d = '0;
		for (int r = 0; r < CELL_HEIGHT; r++) begin
			lit = '0;
			if (r < GLYPH_ROWS) begin
				for (int c = 0; c < GLYPH_COLS; c++)
					lit[c] = cols_s2[c][r];
				if (ul_s2 && r == UNDERLINE_ROW)
					lit = '1;
				if (bold_s2)
					lit = lit | {lit[GLYPH_COLS-2:0], 1'b0};
			end
			rows_d[r] = inv_s2 ? ~{1'b0, lit} : {1'b0, lit};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			busy_q <= 1'b0;
			row_q  <= '0;
		end else begin
			if (ready_s1)
				v_s1 <= cell_valid;
			if (ready_s2)
				v_s2 <= v_s1;
			if (ready_s3)
				v_s3 <= v_s2;
			if (load_row) begin
				busy_q <= 1'b1;
				row_q  <= '0;
			end else if (take) begin
				if (take_last)
					busy_q <= 1'b0;
				row_q <= row_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && cell_valid) begin
			idx_s1  <= idx_d;
			font_s1 <= font_d;
			inv_s1  <= inverse_on;
			ul_s1   <= underline_on;
			bold_s1 <= bold_on;
			x_s1    <= cell_x;
			y_s1    <= cell_y;
		end
		if (ready_s2 && v_s1) begin
			cols_s2 <= font_s1 ? font_cols(idx_s1) : FRAMED_BOX;
			inv_s2  <= inv_s1;
			ul_s2   <= ul_s1;
			bold_s2 <= bold_s1;
			x_s2    <= x_s1;
			y_s2    <= y_s1;
		end
		if (ready_s3 && v_s2) begin
			rows_s3 <= rows_d;
			x_s3    <= x_s2;
			y_s3    <= y_s2;
		end
		if (load_row) begin
			rows_q <= rows_s3;
			x_q    <= x_s3;
			y_q    <= y_s3;
		end
	end

	assign row_valid  = busy_q;
	assign row_pixels = rows_q[row_q];
	assign row_index  = row_q;
	assign pixel_x    = x_q;
	assign pixel_y    = {1'b0, y_q} + {8'b0, row_q};
	assign last_row   = (row_q == LAST_ROW);

endmodule

FILE: tb/terminal_cell_char_generator_tb.sv
// Testbench for terminal_cell_char_generator: drives cell words, predicts the eight
// row words of each cell from its own font table, and checks them in order.
// Depends on tcg_pkg for port types and the box-drawing code points.

import tcg_pkg::*;

typedef struct packed {
	logic [20:0] code_point;
	logic        inverse_on;
	logic        underline_on;
	logic        bold_on;
	logic [9:0]  cell_x;
	logic [9:0]  cell_y;
} cell_word_t;

typedef struct packed {
	row_pix_t          row_pixels;
	logic [ROW_W-1:0]  row_index;
	logic [9:0]        pixel_x;
	logic [10:0]       pixel_y;
	logic              last_row;
} row_word_t;

class cell_row_scoreboard;
	row_word_t expected_rows[$];
	int        mismatches;

	logic [6:0] framed_glyph [GLYPH_COLS] = '{'h7f, 'h41, 'h5d, 'h41, 'h7f};

	// column-major, bit n of a column is glyph row n
	logic [6:0] font_rom [FONT_GLYPHS][GLYPH_COLS] = '{
		'{'h00,'h00,'h00,'h00,'h00}, '{'h00,'h00,'h5f,'h00,'h00}, '{'h00,'h07,'h00,'h07,'h00},
		'{'h14,'h7f,'h14,'h7f,'h14}, '{'h24,'h2a,'h7f,'h2a,'h12}, '{'h23,'h13,'h08,'h64,'h62},
		'{'h36,'h49,'h55,'h22,'h50}, '{'h00,'h05,'h03,'h00,'h00}, '{'h00,'h1c,'h22,'h41,'h00},
		'{'h00,'h41,'h22,'h1c,'h00}, '{'h14,'h08,'h3e,'h08,'h14}, '{'h08,'h08,'h3e,'h08,'h08},
		'{'h00,'h50,'h30,'h00,'h00}, '{'h08,'h08,'h08,'h08,'h08}, '{'h00,'h60,'h60,'h00,'h00},
		'{'h20,'h10,'h08,'h04,'h02}, '{'h3e,'h51,'h49,'h45,'h3e}, '{'h00,'h42,'h7f,'h40,'h00},
		'{'h42,'h61,'h51,'h49,'h46}, '{'h21,'h41,'h45,'h4b,'h31}, '{'h18,'h14,'h12,'h7f,'h10},
		'{'h27,'h45,'h45,'h45,'h39}, '{'h3c,'h4a,'h49,'h49,'h30}, '{'h01,'h71,'h09,'h05,'h03},
		'{'h36,'h49,'h49,'h49,'h36}, '{'h06,'h49,'h49,'h29,'h1e}, '{'h00,'h36,'h36,'h00,'h00},
		'{'h00,'h56,'h36,'h00,'h00}, '{'h08,'h14,'h22,'h41,'h00}, '{'h14,'h14,'h14,'h14,'h14},
		'{'h00,'h41,'h22,'h14,'h08}, '{'h02,'h01,'h51,'h09,'h06}, '{'h32,'h49,'h79,'h41,'h3e},
		'{'h7e,'h11,'h11,'h11,'h7e}, '{'h7f,'h49,'h49,'h49,'h36}, '{'h3e,'h41,'h41,'h41,'h22},
		'{'h7f,'h41,'h41,'h22,'h1c}, '{'h7f,'h49,'h49,'h49,'h41}, '{'h7f,'h09,'h09,'h09,'h01},
		'{'h3e,'h41,'h49,'h49,'h7a}, '{'h7f,'h08,'h08,'h08,'h7f}, '{'h00,'h41,'h7f,'h41,'h00},
		'{'h20,'h40,'h41,'h3f,'h01}, '{'h7f,'h08,'h14,'h22,'h41}, '{'h7f,'h40,'h40,'h40,'h40},
		'{'h7f,'h02,'h0c,'h02,'h7f}, '{'h7f,'h04,'h08,'h10,'h7f}, '{'h3e,'h41,'h41,'h41,'h3e},
		'{'h7f,'h09,'h09,'h09,'h06}, '{'h3e,'h41,'h51,'h21,'h5e}, '{'h7f,'h09,'h19,'h29,'h46},
		'{'h46,'h49,'h49,'h49,'h31}, '{'h01,'h01,'h7f,'h01,'h01}, '{'h3f,'h40,'h40,'h40,'h3f},
		'{'h1f,'h20,'h40,'h20,'h1f}, '{'h3f,'h40,'h38,'h40,'h3f}, '{'h63,'h14,'h08,'h14,'h63},
		'{'h07,'h08,'h70,'h08,'h07}, '{'h61,'h51,'h49,'h45,'h43}, '{'h00,'h7f,'h41,'h41,'h00},
		'{'h02,'h04,'h08,'h10,'h20}, '{'h00,'h41,'h41,'h7f,'h00}, '{'h04,'h02,'h01,'h02,'h04},
		'{'h40,'h40,'h40,'h40,'h40}, '{'h00,'h01,'h02,'h04,'h00}, '{'h20,'h54,'h54,'h54,'h78},
		'{'h7f,'h48,'h44,'h44,'h38}, '{'h38,'h44,'h44,'h44,'h20}, '{'h38,'h44,'h44,'h48,'h7f},
		'{'h38,'h54,'h54,'h54,'h18}, '{'h08,'h7e,'h09,'h01,'h02}, '{'h0c,'h52,'h52,'h52,'h3e},
		'{'h7f,'h08,'h04,'h04,'h78}, '{'h00,'h44,'h7d,'h40,'h00}, '{'h20,'h40,'h44,'h3d,'h00},
		'{'h7f,'h10,'h28,'h44,'h00}, '{'h00,'h41,'h7f,'h40,'h00}, '{'h7c,'h04,'h18,'h04,'h78},
		'{'h7c,'h08,'h04,'h04,'h78}, '{'h38,'h44,'h44,'h44,'h38}, '{'h7c,'h14,'h14,'h14,'h08},
		'{'h08,'h14,'h14,'h18,'h7c}, '{'h7c,'h08,'h04,'h04,'h08}, '{'h48,'h54,'h54,'h54,'h20},
		'{'h04,'h3f,'h44,'h40,'h20}, '{'h3c,'h40,'h40,'h20,'h7c}, '{'h1c,'h20,'h40,'h20,'h1c},
		'{'h3c,'h40,'h30,'h40,'h3c}, '{'h44,'h28,'h10,'h28,'h44}, '{'h0c,'h50,'h50,'h50,'h3c},
		'{'h44,'h64,'h54,'h4c,'h44}, '{'h00,'h08,'h36,'h41,'h00}, '{'h00,'h00,'h7f,'h00,'h00},
		'{'h00,'h41,'h36,'h08,'h00}, '{'h08,'h04,'h08,'h10,'h08}
	};

	function int pending();
		return expected_rows.size();
	endfunction

	function void flag_error(string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%s", msg);
	endfunction

	// builds the eight row words of one accepted cell word
	function void note_cell(cell_word_t c);
		logic [6:0]       cols [GLYPH_COLS];
		logic [IDX_W-1:0] idx;
		logic             printable;
		logic [4:0]       lit;
		row_word_t        r;
		int               row;
		int               col;
		printable = 1'b1;
		case (c.code_point)
			CP_LIGHT_H, CP_HEAVY_H: idx = IDX_DASH;
			CP_LIGHT_V, CP_HEAVY_V: idx = IDX_BAR;
			CP_DOWN_RIGHT, CP_DOWN_LEFT, CP_UP_RIGHT, CP_UP_LEFT, CP_VERT_RIGHT,
			CP_VERT_LEFT, CP_DOWN_HORIZ, CP_UP_HORIZ, CP_CROSS: idx = IDX_PLUS;
			default: begin
				printable = (c.code_point >= CP_FIRST_PRINT) &&
					(c.code_point <= CP_LAST_PRINT);
				idx = IDX_W'(c.code_point - CP_FIRST_PRINT);
			end
		endcase
		for (col = 0; col < GLYPH_COLS; col++)
			cols[col] = printable ? font_rom[idx][col] : framed_glyph[col];
		for (row = 0; row < CELL_HEIGHT; row++) begin
			lit = 5'd0;
			if (row < GLYPH_ROWS) begin
				for (col = 0; col < GLYPH_COLS; col++)
					lit[col] = cols[col][row];
				if (c.underline_on && row == UNDERLINE_ROW)
					lit = 5'h1f;
				if (c.bold_on)
					lit = lit | {lit[3:0], 1'b0};
			end
			r.row_pixels = c.inverse_on ? ~{1'b0, lit} : {1'b0, lit};
			r.row_index  = ROW_W'(row);
			r.pixel_x    = c.cell_x;
			r.pixel_y    = 11'(c.cell_y) + 11'(row);
			r.last_row   = (row == CELL_HEIGHT - 1);
			expected_rows.push_back(r);
		end
	endfunction

	function void check_row(row_word_t got);
		row_word_t want;
		if (expected_rows.size() == 0) begin
			flag_error($sformatf("row word with nothing pending: pix=%b idx=%0d x=%0d y=%0d",
				got.row_pixels, got.row_index, got.pixel_x, got.pixel_y));
			return;
		end
		want = expected_rows.pop_front();
		if (got.row_pixels !== want.row_pixels || got.row_index !== want.row_index ||
			got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y ||
			got.last_row !== want.last_row) begin
			flag_error($sformatf({"row mismatch: exp pix=%b idx=%0d x=%0d y=%0d last=%b",
				" / got pix=%b idx=%0d x=%0d y=%0d last=%b"},
				want.row_pixels, want.row_index, want.pixel_x, want.pixel_y, want.last_row,
				got.row_pixels, got.row_index, got.pixel_x, got.pixel_y, got.last_row));
		end
	endfunction
endclass

module terminal_cell_char_generator_tb;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_GAP        = 6;
	localparam int RANDOM_CELLS   = 300;
	localparam int DRAIN_CYCLES   = 16;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cell_valid;
	logic        cell_stall;
	logic [20:0] code_point;
	logic        inverse_on;
	logic        underline_on;
	logic        bold_on;
	logic [9:0]  cell_x;
	logic [9:0]  cell_y;
	logic        row_valid;
	logic        row_stall;
	row_pix_t    row_pixels;
	logic [2:0]  row_index;
	logic [9:0]  pixel_x;
	logic [10:0] pixel_y;
	logic        last_row;

	cell_row_scoreboard rows_sb;
	bit                 steady_flow;
	int                 idle_cycles;

	terminal_cell_char_generator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cell_valid   (cell_valid),
		.cell_stall   (cell_stall),
		.code_point   (code_point),
		.inverse_on   (inverse_on),
		.underline_on (underline_on),
		.bold_on      (bold_on),
		.cell_x       (cell_x),
		.cell_y       (cell_y),
		.row_valid    (row_valid),
		.row_stall    (row_stall),
		.row_pixels   (row_pixels),
		.row_index    (row_index),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.last_row     (last_row)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// called at a falling edge, returns at the falling edge after the word is taken
	task automatic send_cell(input cell_word_t c);
		int gap;
		gap = steady_flow ? 0 : int'($urandom_range(0, MAX_GAP));
		while (gap > 0) begin
			cell_valid = 1'b0;
			@(negedge clk);
			gap--;
		end
		cell_valid   = 1'b1;
		code_point   = c.code_point;
		inverse_on   = c.inverse_on;
		underline_on = c.underline_on;
		bold_on      = c.bold_on;
		cell_x       = c.cell_x;
		cell_y       = c.cell_y;
		do @(posedge clk); while (cell_stall !== 1'b0);
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (cell_valid && !cell_stall)
				rows_sb.note_cell('{code_point, inverse_on, underline_on, bold_on,
					cell_x, cell_y});
			if (row_valid && !row_stall)
				rows_sb.check_row('{row_pixels, row_index, pixel_x, pixel_y, last_row});
			if ((cell_valid && !cell_stall) || (row_valid && !row_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// row side: random stall before each row word
	initial begin : row_side
		int hold;
		row_stall = 1'b0;
		@(negedge clk);
		forever begin
			hold = steady_flow ? 0 : int'($urandom_range(0, MAX_GAP));
			while (hold > 0) begin
				row_stall = 1'b1;
				@(negedge clk);
				hold--;
			end
			row_stall = 1'b0;
			do @(posedge clk); while (row_valid !== 1'b1);
			@(negedge clk);
		end
	end

	initial begin : stimulus
		logic [20:0] box_cps [13];
		logic [20:0] edge_cps [10];
		cell_word_t  c;
		int          i;
		int          pick;
		box_cps = '{CP_LIGHT_H, CP_HEAVY_H, CP_LIGHT_V, CP_HEAVY_V, CP_DOWN_RIGHT,
			CP_DOWN_LEFT, CP_UP_RIGHT, CP_UP_LEFT, CP_VERT_RIGHT, CP_VERT_LEFT,
			CP_DOWN_HORIZ, CP_UP_HORIZ, CP_CROSS};
		// printable bounds and their neighbors, zero and 'A', a near miss of the box range,
		// and code points at and beyond the end of the Unicode range
		edge_cps = '{21'h000000, 21'h00001f, CP_FIRST_PRINT, 21'h000041, CP_LAST_PRINT,
			21'h00007f, 21'h002504, 21'h10ffff, 21'h110000, 21'h1fffff};
		rows_sb      = new();
		steady_flow  = 1'b0;
		idle_cycles  = 0;
		arst_n       = 1'b0;
		cell_valid   = 1'b0;
		code_point   = '0;
		inverse_on   = 1'b0;
		underline_on = 1'b0;
		bold_on      = 1'b0;
		cell_x       = '0;
		cell_y       = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (i = 0; i < 23; i++) begin
			c.code_point   = (i < 13) ? box_cps[i] : edge_cps[i - 13];
			c.inverse_on   = i[0];
			c.underline_on = i[1];
			c.bold_on      = i[2];
			c.cell_x       = (i[0] ^ i[3]) ? 10'h3ff : 10'h000;
			c.cell_y       = i[1] ? 10'h3ff : 10'h000;
			send_cell(c);
		end

		for (i = 0; i < RANDOM_CELLS; i++) begin
			if (i % 50 == 0)
				steady_flow = ($urandom_range(0, 3) == 0);
			if (i == RANDOM_CELLS / 2) begin
				// hold off until every row word of the cells so far is out
				cell_valid = 1'b0;
				while (rows_sb.pending() != 0) @(negedge clk);
				@(negedge clk);
			end
			pick = int'($urandom_range(0, 99));
			if (pick < 50)
				c.code_point = 21'($urandom_range(CP_FIRST_PRINT, CP_LAST_PRINT));
			else if (pick < 65)
				c.code_point = box_cps[$urandom_range(0, 12)];
			else if (pick < 75)
				c.code_point = 21'($urandom_range(CP_LIGHT_H, 21'h00257f));
			else if (pick < 85)
				c.code_point = 21'($urandom_range(0, 21'h00ffff));
			else
				c.code_point = 21'($urandom_range(0, 21'h1fffff));
			c.inverse_on   = 1'($urandom_range(0, 1));
			c.underline_on = 1'($urandom_range(0, 1));
			c.bold_on      = 1'($urandom_range(0, 1));
			c.cell_x       = 10'($urandom_range(0, 1023));
			c.cell_y       = 10'($urandom_range(0, 1023));
			send_cell(c);
		end

		cell_valid = 1'b0;
		while (rows_sb.pending() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (rows_sb.mismatches == 0 && rows_sb.pending() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
